/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RSMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSMM_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RSMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSMM_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* sv/rsmm_pkg.sv */
`default_nettype none

package rsmm_pkg;

    localparam int unsigned LEAVES_DEF = 1024;

    localparam int unsigned IDX_W  = 11;
    localparam int unsigned VAL_W  = 30;
    localparam int unsigned SUM_W  = 40;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [VAL_W-1:0] VALUE_CAP = VAL_W'(1000000000);
    localparam logic [VAL_W-1:0] EMPTY_MIN = VAL_W'(1000000000);
    localparam logic [IDX_W-1:0] ACTIVE_SIZE_RST = IDX_W'(1024);

    localparam logic [0:0] REG_ACTIVE_SIZE = 1'b0;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] max;
        logic [VAL_W-1:0] min;
    } t_node;

    typedef struct packed {
        logic load;
        logic clr;
        logic wleaf;
        logic wup;
        logic qstep;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic write_ok;
        logic q_nonempty;
        logic q_more;
        logic at_root;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/rsmm_ctrl.sv */
`default_nettype none

module rsmm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rsmm_pkg::t_sts  i_sts,
    output rsmm_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_WLEAF  = 3'd3;
    localparam logic [2:0] S_WUP    = 3'd4;
    localparam logic [2:0] S_QRUN   = 3'd5;
    localparam logic [2:0] S_QOUT   = 3'd6;
    localparam logic [2:0] S_SPARE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_query) begin
                    n_state = i_sts.q_nonempty ? S_QRUN : S_QOUT;
                end else begin
                    n_state = i_sts.write_ok ? S_WLEAF : S_IDLE;
                end
            end
            S_WLEAF: begin
                o_cmd.wleaf = 1'b1;
                n_state     = S_WUP;
            end
            S_WUP: begin
                o_cmd.wup = 1'b1;
                if (i_sts.at_root) begin
                    n_state = S_IDLE;
                end
            end
            S_QRUN: begin
                if (i_sts.q_more) begin
                    o_cmd.qstep = 1'b1;
                end else begin
                    n_state = S_QOUT;
                end
            end
            S_QOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SPARE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* sv/rsmm_dp.sv */
`default_nettype none

module rsmm_dp #(
    parameter int unsigned LEAVES = rsmm_pkg::LEAVES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsmm_pkg::t_cmd                i_cmd,
    output rsmm_pkg::t_sts                o_sts,
    input  logic [rsmm_pkg::IDX_W-1:0]    i_active_size,
    input  logic                          i_req_type,
    input  logic [rsmm_pkg::IDX_W-1:0]    i_first_index,
    input  logic [rsmm_pkg::IDX_W-1:0]    i_last_index,
    input  logic [rsmm_pkg::VAL_W-1:0]    i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rsmm_pkg::SUM_W-1:0]    o_range_sum,
    output logic [rsmm_pkg::VAL_W-1:0]    o_range_max,
    output logic [rsmm_pkg::VAL_W-1:0]    o_range_min
);

    localparam int unsigned NODES = 2 * LEAVES;
    localparam int unsigned AW    = $clog2(NODES);
    localparam int unsigned EW    = (AW + 1 > rsmm_pkg::IDX_W + 1) ? AW + 1
                                                                   : rsmm_pkg::IDX_W + 1;
    localparam logic [EW-1:0] LEAVES_E  = EW'(LEAVES);
    localparam logic [EW-1:0] ONE_E     = EW'(1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODES - 1);

    function automatic rsmm_pkg::t_node node_join(input rsmm_pkg::t_node a,
                                                  input rsmm_pkg::t_node b);
        rsmm_pkg::t_node r;
        r.sum = a.sum + b.sum;
        r.max = (a.max > b.max) ? a.max : b.max;
        r.min = (a.min < b.min) ? a.min : b.min;
        return r;
    endfunction

    rsmm_pkg::t_node r_mem [NODES];
    rsmm_pkg::t_node r_rd_a;
    rsmm_pkg::t_node r_rd_b;

    logic [AW-1:0]   r_clr_addr;
    logic [EW-1:0]   r_k;
    logic [EW-1:0]   r_l;
    logic [EW-1:0]   r_r;
    rsmm_pkg::t_node r_node;
    rsmm_pkg::t_node r_acc;
    rsmm_pkg::t_node n_acc;
    logic            r_va;
    logic            r_vb;
    logic            r_is_query;
    logic            r_write_ok;
    logic            r_q_nonempty;
    logic            r_out_valid;
    rsmm_pkg::t_node r_out;

    logic [EW-1:0]   act_e;
    logic [EW-1:0]   used;
    logic [EW-1:0]   first_e;
    logic [EW-1:0]   last_e;
    logic [EW-1:0]   lo;
    logic [EW-1:0]   hi;
    logic [rsmm_pkg::VAL_W-1:0] vsat;
    logic [EW-1:0]   sib;
    logic [EW-1:0]   r_dec;
    rsmm_pkg::t_node parent;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    rsmm_pkg::t_node mem_wd;
    logic [AW-1:0]   mem_ra_a;
    logic [AW-1:0]   mem_ra_b;
    logic [rsmm_pkg::SUM_W-1:0] add_a;
    logic [rsmm_pkg::SUM_W-1:0] add_b;

    always_comb begin
        act_e   = EW'(i_active_size);
        used    = (act_e > LEAVES_E) ? LEAVES_E : act_e;
        first_e = EW'(i_first_index);
        last_e  = EW'(i_last_index);
        lo      = (first_e == '0) ? ONE_E : first_e;
        hi      = (last_e < used) ? last_e : used;
        vsat    = (i_value > rsmm_pkg::VALUE_CAP) ? rsmm_pkg::VALUE_CAP : i_value;
    end

    assign sib    = r_k ^ ONE_E;
    assign r_dec  = r_r - ONE_E;
    assign parent = node_join(r_node, r_rd_a);

    always_comb begin
        mem_we = i_cmd.clr | i_cmd.wleaf | i_cmd.wup;
        mem_wa = i_cmd.clr ? r_clr_addr : r_k[AW-1:0];
        if (i_cmd.clr) begin
            mem_wd = '0;
        end else if (i_cmd.wleaf) begin
            mem_wd = r_node;
        end else begin
            mem_wd = parent;
        end
        mem_ra_a = i_cmd.qstep ? r_l[AW-1:0] : sib[AW-1:0];
        mem_ra_b = r_dec[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[mem_ra_a];
        r_rd_b <= r_mem[mem_ra_b];
    end

    always_comb begin
        add_a = r_va ? r_rd_a.sum : '0;
        add_b = r_vb ? r_rd_b.sum : '0;
        n_acc.sum = r_acc.sum + add_a + add_b;
        n_acc.max = r_acc.max;
        if (r_va && (r_rd_a.max > n_acc.max)) begin
            n_acc.max = r_rd_a.max;
        end
        if (r_vb && (r_rd_b.max > n_acc.max)) begin
            n_acc.max = r_rd_b.max;
        end
        n_acc.min = r_acc.min;
        if (r_va && (r_rd_a.min < n_acc.min)) begin
            n_acc.min = r_rd_a.min;
        end
        if (r_vb && (r_rd_b.min < n_acc.min)) begin
            n_acc.min = r_rd_b.min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_va <= i_cmd.qstep & r_l[0];
            r_vb <= i_cmd.qstep & r_r[0];
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_query   <= (i_req_type == rsmm_pkg::REQ_QUERY);
            r_write_ok   <= (first_e != '0) && (first_e <= used);
            r_q_nonempty <= (lo <= hi);
            r_k          <= LEAVES_E + first_e - ONE_E;
            r_l          <= LEAVES_E + lo - ONE_E;
            r_r          <= LEAVES_E + hi;
            r_node.sum   <= rsmm_pkg::SUM_W'(vsat);
            r_node.max   <= vsat;
            r_node.min   <= vsat;
            r_acc.sum    <= '0;
            r_acc.max    <= '0;
            r_acc.min    <= rsmm_pkg::EMPTY_MIN;
        end else begin
            r_acc <= n_acc;
            if (i_cmd.wleaf) begin
                r_k <= r_k >> 1;
            end
            if (i_cmd.wup) begin
                r_k    <= r_k >> 1;
                r_node <= parent;
            end
            if (i_cmd.qstep) begin
                r_l <= (r_l + EW'(r_l[0])) >> 1;
                r_r <= r_r >> 1;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    always_comb begin
        o_sts.clr_last   = (r_clr_addr == LAST_ADDR);
        o_sts.is_query   = r_is_query;
        o_sts.write_ok   = r_write_ok;
        o_sts.q_nonempty = r_q_nonempty;
        o_sts.q_more     = (r_l < r_r);
        o_sts.at_root    = (r_k == ONE_E);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out.sum;
    assign o_range_max = r_out.max;
    assign o_range_min = r_out.min;

endmodule

`default_nettype wire

/* sv/range_sum_max_min_tree.sv */
`default_nettype none

`include "assert_macros.svh"

// Segment tree over LEAVES slots that keeps the sum, maximum and minimum of every node in one
// node memory of 2*LEAVES entries. After reset the block clears that memory and holds
// o_in_ready low; configuration writes are taken during that time. A write request with a
// valid index stores one slot and then climbs to the root, one level per cycle, pairing the
// new node with its sibling read from the memory. A query request walks both range bounds up
// the tree, one level per cycle, reading up to two nodes per level; its result waits in an
// output register while the next request is accepted.
module range_sum_max_min_tree #(
    parameter int unsigned LEAVES = rsmm_pkg::LEAVES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [rsmm_pkg::IDX_W-1:0]    i_first_index,
    input  logic [rsmm_pkg::IDX_W-1:0]    i_last_index,
    input  logic [rsmm_pkg::VAL_W-1:0]    i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rsmm_pkg::SUM_W-1:0]    o_range_sum,
    output logic [rsmm_pkg::VAL_W-1:0]    o_range_max,
    output logic [rsmm_pkg::VAL_W-1:0]    o_range_min,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsmm_pkg::ADDR_W-1:0]   paddr,
    input  logic [rsmm_pkg::DATA_W-1:0]   pwdata,
    output logic [rsmm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [rsmm_pkg::IDX_W-1:0] r_active_size;
    logic                       sel_active;
    rsmm_pkg::t_cmd             cmd;
    rsmm_pkg::t_sts             sts;

    assign pready     = 1'b1;
    assign sel_active = (paddr[rsmm_pkg::ADDR_W-1:2] == rsmm_pkg::REG_ACTIVE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= rsmm_pkg::ACTIVE_SIZE_RST;
        end else if (psel && penable && pwrite && pready && sel_active) begin
            r_active_size <= pwdata[rsmm_pkg::IDX_W-1:0];
        end
    end

    assign prdata = sel_active ? rsmm_pkg::DATA_W'(r_active_size) : '0;

    rsmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsmm_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_active_size (r_active_size),
        .i_req_type    (i_req_type),
        .i_first_index (i_first_index),
        .i_last_index  (i_last_index),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_range_sum   (o_range_sum),
        .o_range_max   (o_range_max),
        .o_range_min   (o_range_min)
    );

    `RSMM_NEVER(a_ready_while_busy, i_clk, i_rst_n, o_in_ready && (cmd.clr || cmd.wleaf || cmd.wup || cmd.qstep || cmd.out_load), "input ready while the datapath is busy")
    `RSMM_ASSERT(a_root_ends_write, i_clk, i_rst_n, (cmd.wup && sts.at_root) |=> o_in_ready, "write did not finish at the root")
    `RSMM_ASSERT(a_result_from_query, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(cmd.out_load), "result without a finished query")

endmodule

`default_nettype wire
